>>> hw/rtl/cau_pkg.sv
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int HALF = DATA_WIDTH;           // split point for wide multiplies
    localparam int MW   = 2 * DATA_WIDTH;       // operand product
    localparam int SW   = DATA_WIDTH + 1;       // operand sum
    localparam int PW   = 2 * DATA_WIDTH + 2;   // complex product part
    localparam int DW   = 2 * SW + 1;           // squared magnitude
    localparam int NW   = PW + SW + 1;          // dividend
    localparam int QW   = DATA_WIDTH;           // quotient bits kept
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [FRAC_BITS-1:0] FRAC_MASK = '1;
    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CONJ, OP_INV, OP_PAR, OP_SCALE
    } op_t;

    typedef struct packed {
        op_t                          op;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic                  valid;
        logic                  pop;
    } qctl_t;

    typedef struct packed {
        logic                  is_div;
        logic signed [NW-1:0]  n_re;
        logic signed [NW-1:0]  n_im;
        logic [DW-1:0]         den;
        logic signed [PW-1:0]  d_re;
        logic signed [PW-1:0]  d_im;
    } work_t;

    typedef struct packed {
        logic                  is_div;
        logic                  dz;
        logic                  neg_re;
        logic                  neg_im;
        logic                  big_re;
        logic                  big_im;
        logic [DW-1:0]         den;
        logic [DW-1:0]         rem_re;
        logic [DW-1:0]         rem_im;
        logic [QW-1:0]         dv_re;
        logic [QW-1:0]         dv_im;
        logic [QW-1:0]         q_re;
        logic [QW-1:0]         q_im;
        logic signed [PW-1:0]  d_re;
        logic signed [PW-1:0]  d_im;
    } dstage_t;

    // divide by 2^FRAC_BITS, toward zero
    function automatic logic signed [PW-1:0] trunc_frac(input logic signed [PW-1:0] x);
        logic signed [PW-1:0] bias;
        logic signed [PW-1:0] s;
        bias = x[PW-1] ? $signed(PW'(FRAC_MASK)) : $signed(PW'(0));
        s = x + bias;
        return s >>> FRAC_BITS;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_part(
        input logic signed [PW-1:0] x, output logic ovf);
        ovf = 1'b0;
        if (x > PW'(MAX_VAL)) begin
            ovf = 1'b1;
            return MAX_VAL;
        end else if (x < PW'(MIN_VAL)) begin
            ovf = 1'b1;
            return MIN_VAL;
        end
        return x[DATA_WIDTH-1:0];
    endfunction

endpackage

>>> hw/rtl/cau_front.sv
module cau_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tuser,  // req_type[2:0]
    input  logic [127:0]        s_tdata,  // a_re, a_im, b_re, b_im
    input  logic                pop,
    output cau_pkg::qctl_t      qctl,
    output cau_pkg::req_t       q_data
);
    import cau_pkg::*;

    req_t            mem_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    count_reg, count_next;
    logic            push;
    logic            do_pop;
    req_t            req;

    always_comb begin
        req.op   = op_t'(s_tuser[2:0]);
        req.a_re = s_tdata[DATA_WIDTH-1:0];
        req.a_im = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        req.b_re = s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
        req.b_im = s_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH];
    end

    assign s_tready   = (count_reg != (QAW+1)'(QDEPTH));
    assign push       = s_tvalid && s_tready;
    assign qctl.valid = (count_reg != '0);
    assign do_pop     = pop && qctl.valid;
    assign qctl.pop   = do_pop;
    assign q_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= req;
        end
    end

endmodule

>>> hw/rtl/cau_back.sv
module cau_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  cau_pkg::qctl_t qctl,
    input  cau_pkg::req_t  q_data,
    output logic           w_valid,
    output cau_pkg::work_t w_data
);
    import cau_pkg::*;

    logic [4:0] vld_reg;

    // stage 1: operands and sums
    req_t                r1_reg;
    logic signed [SW-1:0] sr1_reg, si1_reg;

    // stage 2: operand products
    req_t                r2_reg;
    logic signed [SW-1:0] sr2_reg, si2_reg;
    logic signed [MW-1:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic signed [2*SW-1:0] m4_reg, m5_reg;
    logic signed [SW-1:0] x2, y2;

    // stage 3: combine
    op_t                  op3_reg;
    work_t                w3_reg, w3_next;
    logic signed [PW-1:0] pr3_reg, pi3_reg, pr3, pi3;
    logic signed [SW-1:0] sr3_reg, si3_reg;

    // stage 4: partial products for parallel
    op_t                  op4_reg;
    work_t                w4_reg;
    logic signed [HALF+SW+1:0] hrs_reg, his_reg, hps_reg, hqs_reg;
    logic signed [HALF+SW:0]   lrs_reg, lis_reg, lps_reg, lqs_reg;

    // stage 5
    work_t                w5_reg, w5_next;
    logic signed [NW-1:0] prsr, pisi, pisr, prsi;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], qctl.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg  <= q_data;
            sr1_reg <= SW'(q_data.a_re) + SW'(q_data.b_re);
            si1_reg <= SW'(q_data.a_im) + SW'(q_data.b_im);
        end
    end

    always_comb begin
        case (r1_reg.op)
            OP_DIV: begin
                x2 = SW'(r1_reg.b_re);
                y2 = SW'(r1_reg.b_im);
            end
            OP_INV: begin
                x2 = SW'(r1_reg.a_re);
                y2 = SW'(r1_reg.a_im);
            end
            default: begin
                x2 = sr1_reg;
                y2 = si1_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg  <= r1_reg;
            sr2_reg <= sr1_reg;
            si2_reg <= si1_reg;
            m0_reg  <= MW'(r1_reg.a_re) * MW'(r1_reg.b_re);
            m1_reg  <= MW'(r1_reg.a_im) * MW'(r1_reg.b_im);
            m2_reg  <= MW'(r1_reg.a_re) * MW'(r1_reg.b_im);
            m3_reg  <= MW'(r1_reg.a_im) * MW'(r1_reg.b_re);
            m4_reg  <= (2*SW)'(x2) * (2*SW)'(x2);
            m5_reg  <= (2*SW)'(y2) * (2*SW)'(y2);
        end
    end

    always_comb begin
        pr3 = PW'(m0_reg) - PW'(m1_reg);
        pi3 = PW'(m2_reg) + PW'(m3_reg);
        w3_next.is_div = 1'b0;
        w3_next.n_re   = '0;
        w3_next.n_im   = '0;
        w3_next.den    = DW'($unsigned(m4_reg)) + DW'($unsigned(m5_reg));
        w3_next.d_re   = '0;
        w3_next.d_im   = '0;
        case (r2_reg.op)
            OP_ADD: begin
                w3_next.d_re = PW'(r2_reg.a_re) + PW'(r2_reg.b_re);
                w3_next.d_im = PW'(r2_reg.a_im) + PW'(r2_reg.b_im);
            end
            OP_SUB: begin
                w3_next.d_re = PW'(r2_reg.a_re) - PW'(r2_reg.b_re);
                w3_next.d_im = PW'(r2_reg.a_im) - PW'(r2_reg.b_im);
            end
            OP_MUL: begin
                w3_next.d_re = trunc_frac(pr3);
                w3_next.d_im = trunc_frac(pi3);
            end
            OP_DIV: begin
                w3_next.is_div = 1'b1;
                w3_next.n_re   = (NW'(m0_reg) + NW'(m1_reg)) <<< FRAC_BITS;
                w3_next.n_im   = (NW'(m3_reg) - NW'(m2_reg)) <<< FRAC_BITS;
            end
            OP_CONJ: begin
                w3_next.d_re = PW'(r2_reg.a_re);
                w3_next.d_im = -PW'(r2_reg.a_im);
            end
            OP_INV: begin
                w3_next.is_div = 1'b1;
                w3_next.n_re   = NW'(r2_reg.a_re) <<< (2*FRAC_BITS);
                w3_next.n_im   = (-NW'(r2_reg.a_im)) <<< (2*FRAC_BITS);
            end
            OP_PAR: begin
                w3_next.is_div = 1'b1;
            end
            default: begin
                w3_next.d_re = trunc_frac(PW'(m0_reg));
                w3_next.d_im = trunc_frac(PW'(m3_reg));
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op3_reg <= r2_reg.op;
            w3_reg  <= w3_next;
            pr3_reg <= pr3;
            pi3_reg <= pi3;
            sr3_reg <= sr2_reg;
            si3_reg <= si2_reg;
        end
    end

    // wide parts split at HALF: high part signed, low part unsigned
    always_ff @(posedge aclk) begin
        if (en) begin
            op4_reg <= op3_reg;
            w4_reg  <= w3_reg;
            hrs_reg <= (HALF+SW+2)'($signed(pr3_reg[PW-1:HALF])) * (HALF+SW+2)'(sr3_reg);
            his_reg <= (HALF+SW+2)'($signed(pi3_reg[PW-1:HALF])) * (HALF+SW+2)'(si3_reg);
            hps_reg <= (HALF+SW+2)'($signed(pi3_reg[PW-1:HALF])) * (HALF+SW+2)'(sr3_reg);
            hqs_reg <= (HALF+SW+2)'($signed(pr3_reg[PW-1:HALF])) * (HALF+SW+2)'(si3_reg);
            lrs_reg <= (HALF+SW+1)'($signed({1'b0, pr3_reg[HALF-1:0]})) * (HALF+SW+1)'(sr3_reg);
            lis_reg <= (HALF+SW+1)'($signed({1'b0, pi3_reg[HALF-1:0]})) * (HALF+SW+1)'(si3_reg);
            lps_reg <= (HALF+SW+1)'($signed({1'b0, pi3_reg[HALF-1:0]})) * (HALF+SW+1)'(sr3_reg);
            lqs_reg <= (HALF+SW+1)'($signed({1'b0, pr3_reg[HALF-1:0]})) * (HALF+SW+1)'(si3_reg);
        end
    end

    always_comb begin
        prsr = (NW'(hrs_reg) <<< HALF) + NW'(lrs_reg);
        pisi = (NW'(his_reg) <<< HALF) + NW'(lis_reg);
        pisr = (NW'(hps_reg) <<< HALF) + NW'(lps_reg);
        prsi = (NW'(hqs_reg) <<< HALF) + NW'(lqs_reg);
        w5_next = w4_reg;
        if (op4_reg == OP_PAR) begin
            w5_next.n_re = prsr + pisi;
            w5_next.n_im = pisr - prsi;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w5_reg <= w5_next;
        end
    end

    assign w_valid = vld_reg[4];
    assign w_data  = w5_reg;

endmodule

>>> hw/rtl/cau_div.sv
module cau_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           w_valid,
    input  cau_pkg::work_t w_data,
    output logic           m_tvalid,
    output logic [63:0]    m_tdata,
    output logic [7:0]     m_tuser
);
    import cau_pkg::*;

    dstage_t      st_reg  [QW+1];
    logic [QW:0]  vld_reg;
    dstage_t      st0;
    logic [NW-1:0] mag_re, mag_im, lim;

    logic                         out_vld_reg;
    logic signed [DATA_WIDTH-1:0] re_reg, im_reg, re_next, im_next;
    logic                         ovf_reg, dz_reg, ovf_next, dz_next;

    always_comb begin
        mag_re = w_data.n_re[NW-1] ? $unsigned(-w_data.n_re) : $unsigned(w_data.n_re);
        mag_im = w_data.n_im[NW-1] ? $unsigned(-w_data.n_im) : $unsigned(w_data.n_im);
        lim    = NW'({w_data.den, {QW{1'b0}}});
        st0.is_div = w_data.is_div;
        st0.dz     = (w_data.den == '0);
        st0.neg_re = w_data.n_re[NW-1];
        st0.neg_im = w_data.n_im[NW-1];
        st0.big_re = (mag_re >= lim);
        st0.big_im = (mag_im >= lim);
        st0.den    = w_data.den;
        st0.rem_re = DW'(mag_re >> QW);
        st0.rem_im = DW'(mag_im >> QW);
        st0.dv_re  = mag_re[QW-1:0];
        st0.dv_im  = mag_im[QW-1:0];
        st0.q_re   = '0;
        st0.q_im   = '0;
        st0.d_re   = w_data.d_re;
        st0.d_im   = w_data.d_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW-1:0], w_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        dstage_t      nx;
        logic [DW:0]  t_re, t_im;
        logic         qb_re, qb_im;
        always_comb begin
            nx    = st_reg[k-1];
            t_re  = {st_reg[k-1].rem_re, st_reg[k-1].dv_re[QW-1]};
            t_im  = {st_reg[k-1].rem_im, st_reg[k-1].dv_im[QW-1]};
            qb_re = (t_re >= {1'b0, st_reg[k-1].den});
            qb_im = (t_im >= {1'b0, st_reg[k-1].den});
            if (qb_re) t_re = t_re - {1'b0, st_reg[k-1].den};
            if (qb_im) t_im = t_im - {1'b0, st_reg[k-1].den};
            nx.rem_re = t_re[DW-1:0];
            nx.rem_im = t_im[DW-1:0];
            nx.dv_re  = {st_reg[k-1].dv_re[QW-2:0], 1'b0};
            nx.dv_im  = {st_reg[k-1].dv_im[QW-2:0], 1'b0};
            nx.q_re   = {st_reg[k-1].q_re[QW-2:0], qb_re};
            nx.q_im   = {st_reg[k-1].q_im[QW-2:0], qb_im};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= nx;
            end
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] fin_q(
        input logic neg, input logic big, input logic [QW-1:0] q, output logic ovf);
        ovf = 1'b0;
        if (big || (!neg && q[QW-1]) || (neg && q > {1'b1, {(QW-1){1'b0}}})) begin
            ovf = 1'b1;
            return neg ? MIN_VAL : MAX_VAL;
        end
        return neg ? -$signed(q) : $signed(q);
    endfunction

    always_comb begin
        logic o_re, o_im;
        dstage_t s;
        s = st_reg[QW];
        o_re = 1'b0;
        o_im = 1'b0;
        dz_next = 1'b0;
        if (!s.is_div) begin
            re_next = sat_part(s.d_re, o_re);
            im_next = sat_part(s.d_im, o_im);
        end else if (s.dz) begin
            re_next = MAX_VAL;
            im_next = MAX_VAL;
            o_re    = 1'b1;
            dz_next = 1'b1;
        end else begin
            re_next = fin_q(s.neg_re, s.big_re, s.q_re, o_re);
            im_next = fin_q(s.neg_im, s.big_im, s.q_im, o_im);
        end
        ovf_next = o_re || o_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            ovf_reg <= ovf_next;
            dz_reg  <= dz_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {im_reg, re_reg};
    assign m_tuser  = {6'b0, dz_reg, ovf_reg};

endmodule

>>> hw/rtl/complex_arithmetic_unit.sv
// Channel   Dir  tdata (low bit up)                  tuser (low bit up)
// s_        in   a_re, a_im, b_re, b_im (128 bits)    req_type[2:0]
// m_        out  res_re, res_im (64 bits)             overflow, div_by_zero
//
// One transaction per cycle sustained while the output is not stalled; from acceptance
// to m_tvalid a result passes five multiply/combine stages, the quotient entry
// register, the 32-stage quotient pipeline and the output register.
// Synchronous active-low reset clears the queue and all valid bits.
// m_tready low while m_tvalid is high stalls the whole back pipeline; the 4-entry
// input queue keeps taking transactions until it fills.
module complex_arithmetic_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [7:0]   s_tuser,   // req_type[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_re, res_im
    output logic [7:0]   m_tuser    // overflow, div_by_zero
);
    import cau_pkg::*;

    qctl_t qctl;
    req_t  q_data;
    work_t w_data;
    logic  w_valid;
    logic  en;

    assign en = !m_tvalid || m_tready;

    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .pop      (en),
        .qctl     (qctl),
        .q_data   (q_data)
    );

    cau_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .qctl    (qctl),
        .q_data  (q_data),
        .w_valid (w_valid),
        .w_data  (w_data)
    );

    cau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .w_valid  (w_valid),
        .w_data   (w_data),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> hw/rtl/cau_checker.sv
module cau_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [7:0]  m_tuser
);
    import cau_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_dz_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("divide by zero without overflow");

    a_dz_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == {MAX_VAL, MAX_VAL})
        else $error("divide by zero value not saturated");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
